/* hdl/spq_pkg.sv */
// Shared types and constants for the sorted max-first priority queue.
// Used by spq_cell and sorted_priority_queue_max; no dependencies.
package spq_pkg;

   localparam int DATA_W        = 32;
   localparam int OCC_W         = 7;
   localparam int DEPTH_DEFAULT = 64;

   // Head value reported when nothing is held
   localparam logic signed [DATA_W-1:0] EMPTY_HEAD = -32'sd1;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   // Command broadcast to every cell in the row
   typedef struct packed {
      logic                     ins;
      logic                     rem;
      logic signed [DATA_W-1:0] value;
   } cmd_type;

endpackage

/* hdl/spq_cell.sv */
// One slot of the sorted row: holds a value, decides keep/take/shift.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
   input  logic                     clock,
   input  cmd_type                  cmd,
   input  logic                     occupied,
   input  logic                     left_keep,
   input  logic signed [DATA_W-1:0] left_value,
   input  logic signed [DATA_W-1:0] right_value,
   output logic                     keep_out,
   output logic signed [DATA_W-1:0] value_out,
   output logic signed [DATA_W-1:0] value_next
);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   // Entry stays put when it is held and not smaller than the new value
   assign keep_out = occupied && (value_ff >= cmd.value);

   // Insert: keep, take new value at the boundary, or shift from the left.
   // Remove: shift from the right.
   always_comb begin
      value_in = value_ff;
      if (cmd.ins) begin
         if (!keep_out) begin
            value_in = left_keep ? cmd.value : left_value;
         end
      end else if (cmd.rem) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out  = value_ff;
   assign value_next = value_in;

endmodule

/* hdl/sorted_priority_queue_max.sv */
// Sorted max-first priority queue built as a row of compare/shift cells.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   Request channel (req_valid/req_stall, req_func, req_item_value):
//   req_func FUNC_INSERT places req_item_value after all held values
//   that are greater or equal; FUNC_REMOVE drops the head entry.
//   Response channel (rsp_valid/rsp_stall): one response per request with
//   the head after the operation (-1 and rsp_is_empty when nothing is
//   held), the occupancy, and rsp_overflow for an insert refused when full.
//   Removing from an empty queue changes nothing.
// Timing:
//   Every cell compares against the broadcast value and moves in the same
//   cycle, and the response is registered, so it shows in the cycle after
//   the request is taken; throughput 1 request per cycle unless stalled.
//   The response register decouples the sides; a new request is taken
//   whenever the response register is empty or being drained.
// Reset:
//   Synchronous reset empties the queue and clears the response valid flag.
//   Cell contents are not cleared; the held count marks which are valid.
// Stall:
//   While rsp_stall holds a pending response, req_stall is raised and the
//   response stays unchanged.
module sorted_priority_queue_max import spq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_func,
   input  logic signed [DATA_W-1:0] req_item_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_head_value,
   output logic                     rsp_is_empty,
   output logic [OCC_W-1:0]         rsp_occupancy,
   output logic                     rsp_overflow
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   logic                     accept;
   logic                     is_full;
   cmd_type                  cmd;
   logic [CNT_W-1:0]         count_ff, count_in;

   logic                     keep   [DEPTH];
   logic signed [DATA_W-1:0] vals   [DEPTH];
   logic signed [DATA_W-1:0] nexts  [DEPTH];

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_head_ff;
   logic                     rsp_empty_ff;
   logic [OCC_W-1:0]         rsp_occ_ff;
   logic                     rsp_ovf_ff;

   // Handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_full   = (count_ff == FULL_COUNT);

   // Command broadcast to the row
   always_comb begin
      cmd.value = req_item_value;
      cmd.ins   = accept && (req_func == FUNC_INSERT) && !is_full;
      cmd.rem   = accept && (req_func == FUNC_REMOVE) && (count_ff != '0);
   end

   // Held count
   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.rem) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                     lk;
      logic signed [DATA_W-1:0] lv;
      logic signed [DATA_W-1:0] rv;
      if (i == 0) begin : g_first
         assign lk = 1'b1;
         assign lv = req_item_value;
      end else begin : g_mid
         assign lk = keep[i-1];
         assign lv = vals[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign rv = vals[i];
      end else begin : g_inner
         assign rv = vals[i+1];
      end
      spq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (count_ff > CNT_W'(i)),
         .left_keep  (lk),
         .left_value (lv),
         .right_value(rv),
         .keep_out   (keep[i]),
         .value_out  (vals[i]),
         .value_next (nexts[i])
      );
   end

   // Response register
   assign rsp_valid_in = accept || req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_head_ff  <= (count_in == '0) ? EMPTY_HEAD : nexts[0];
         rsp_empty_ff <= (count_in == '0);
         rsp_occ_ff   <= OCC_W'(count_in);
         rsp_ovf_ff   <= (req_func == FUNC_INSERT) && is_full;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_head_value = rsp_head_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_occupancy  = rsp_occ_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("held count beyond depth");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_INSERT && is_full) |=> (count_ff == FULL_COUNT))
      else $error("dropped insert changed the count");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |-> (rsp_head_value == EMPTY_HEAD))
      else $error("empty response without empty head value");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_REMOVE && count_ff != '0)
         |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("remove did not decrement count");

endmodule
